// ----- src/fsp_pkg.sv -----
// fsp_pkg: shared constants, operation codes and cell control type for the
// first substring position block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int unsigned PATTERN_MAX = 32;
    localparam longint unsigned TEXT_MAX = 64'd65535;

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int unsigned CNT_W = $clog2(TEXT_MAX + 1);
    localparam int unsigned POS_W = CNT_W + 1;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OP_W = 2;

    localparam logic [CNT_W-1:0] TEXT_MAX_C = CNT_W'(TEXT_MAX);
    localparam logic [LEN_W-1:0] PATTERN_MAX_C = LEN_W'(PATTERN_MAX);

    typedef enum logic [OP_W-1:0] {
        OP_PAT_BYTE = 2'd0,
        OP_PAT_END  = 2'd1,
        OP_TXT_BYTE = 2'd2,
        OP_TXT_END  = 2'd3
    } t_op;

    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/first_substring_position_top.sv -----
// first_substring_position_top: stream front end, counters and result register
// around a row of fsp_cell compare cells; depends on fsp_pkg and fsp_cell
`timescale 1ns / 1ps
`default_nettype none

// Finds the first one-based position of a stored pattern (up to 32 bytes)
// in a streamed text. Pattern bytes, text bytes and end markers can
// arrive back to back at one per clock, as far as input is not stalled.
// Pattern and text bytes shift into a row of 32 cells that compare
// all window positions at once; the compare of a text byte is resolved in
// the cycle after it enters, in time for an end-of-text transaction that
// follows directly. End of text produces one result transaction
// (match_position in tdata[16:0], 0 when there is no match, text length
// plus one for an empty pattern; tuser[0] pattern too long, tuser[1] text
// too long). Input is stalled only while a result is waiting and the sink
// is not ready. The pattern is kept for later texts.
module first_substring_position_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,  // [7:0] byte_value
    input  wire  [1:0]  i_s_axis_tuser,  // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [16:0] match_position, rest zero
    output logic [1:0]  o_m_axis_tuser   // [0] pattern_too_long, [1] text_too_long
);

    localparam int unsigned N = fsp_pkg::PATTERN_MAX;

    // control state
    logic [fsp_pkg::LEN_W-1:0] r_len, n_len;
    logic [fsp_pkg::CNT_W-1:0] r_count, n_count;
    logic [fsp_pkg::POS_W-1:0] r_first, n_first;
    logic                      r_povf, n_povf;
    logic                      r_tovf, n_tovf;
    logic                      r_closed, n_closed;
    logic                      r_chk, n_chk;
    logic                      r_ovalid, n_ovalid;
    logic [fsp_pkg::POS_W-1:0] r_opos, n_opos;
    logic                      r_opovf, n_opovf;
    logic                      r_otovf, n_otovf;

    logic                      s_acc;
    fsp_pkg::t_op              op;
    fsp_pkg::t_cell_ctrl       ctrl;
    logic                      pat_clear;
    logic                      clr;
    logic                      hit;
    logic                      all_eq;
    logic [fsp_pkg::POS_W-1:0] first_eff;
    logic [fsp_pkg::CNT_W-1:0] eff_cnt;
    logic [fsp_pkg::POS_W-1:0] eff_first;
    logic                      eff_tovf;

    logic [fsp_pkg::BYTE_W-1:0] w_pat [0:N];
    logic [fsp_pkg::BYTE_W-1:0] w_txt [0:N];
    logic                       w_act [0:N];
    logic                       w_act_in [0:N-1];
    logic [N-1:0]               w_eq;

    assign o_s_axis_tready = !r_ovalid || i_m_axis_tready;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign op    = fsp_pkg::t_op'(i_s_axis_tuser);

    assign w_pat[0] = i_s_axis_tdata;
    assign w_txt[0] = i_s_axis_tdata;
    assign w_act[0] = 1'b1;

    // cell row
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_act_in[g] = w_act[g];
            end else begin : g_body
                assign w_act_in[g] = w_act[g] && !pat_clear;
            end
            fsp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl),
                .i_pat   (w_pat[g]),
                .i_act   (w_act_in[g]),
                .i_txt   (w_txt[g]),
                .o_pat   (w_pat[g+1]),
                .o_act   (w_act[g+1]),
                .o_txt   (w_txt[g+1]),
                .o_eq    (w_eq[g])
            );
        end
    endgenerate

    assign all_eq = &w_eq;

    // resolve the compare of the previous text byte
    assign hit = r_chk && (r_first == '0) && (r_len != '0) &&
                 (fsp_pkg::POS_W'(r_count) >= fsp_pkg::POS_W'(r_len)) && all_eq;
    assign first_eff = hit ?
        (fsp_pkg::POS_W'(r_count) - fsp_pkg::POS_W'(r_len) + fsp_pkg::POS_W'(1)) :
        r_first;

    always_comb begin
        ctrl      = '0;
        pat_clear = 1'b0;
        clr       = 1'b0;
        n_len     = r_len;
        n_count   = r_count;
        n_first   = first_eff;
        n_povf    = r_povf;
        n_tovf    = r_tovf;
        n_closed  = r_closed;
        n_chk     = 1'b0;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_opos    = r_opos;
        n_opovf   = r_opovf;
        n_otovf   = r_otovf;
        eff_cnt   = r_count;
        eff_first = first_eff;
        eff_tovf  = r_tovf;
        if (s_acc) begin
            unique case (op) inside
                fsp_pkg::OP_PAT_BYTE: clr = r_closed;
                fsp_pkg::OP_PAT_END:  clr = 1'b1;
                fsp_pkg::OP_TXT_BYTE,
                fsp_pkg::OP_TXT_END:  clr = !r_closed;
                default:              clr = 1'b0;
            endcase
            if (clr) begin
                eff_cnt   = '0;
                eff_first = '0;
                eff_tovf  = 1'b0;
            end
            n_count = eff_cnt;
            n_first = eff_first;
            n_tovf  = eff_tovf;
            unique case (op)
                fsp_pkg::OP_PAT_BYTE: begin
                    if (r_closed) begin
                        // new pattern
                        n_closed       = 1'b0;
                        n_povf         = 1'b0;
                        n_len          = fsp_pkg::LEN_W'(1);
                        pat_clear      = 1'b1;
                        ctrl.pat_shift = 1'b1;
                    end else if (r_len < fsp_pkg::PATTERN_MAX_C) begin
                        n_len          = r_len + fsp_pkg::LEN_W'(1);
                        ctrl.pat_shift = 1'b1;
                    end else begin
                        n_povf = 1'b1;
                    end
                end
                fsp_pkg::OP_PAT_END: begin
                    n_closed = 1'b1;
                end
                fsp_pkg::OP_TXT_BYTE: begin
                    n_closed = 1'b1;
                    if (eff_cnt == fsp_pkg::TEXT_MAX_C) begin
                        n_tovf = 1'b1;
                    end else begin
                        n_count        = eff_cnt + fsp_pkg::CNT_W'(1);
                        ctrl.txt_shift = 1'b1;
                        n_chk          = 1'b1;
                    end
                end
                fsp_pkg::OP_TXT_END: begin
                    n_closed = 1'b1;
                    n_ovalid = 1'b1;
                    n_opos   = (r_len == '0) ?
                        (fsp_pkg::POS_W'(eff_cnt) + fsp_pkg::POS_W'(1)) : eff_first;
                    n_opovf  = r_povf;
                    n_otovf  = eff_tovf;
                    n_count  = '0;
                    n_first  = '0;
                    n_tovf   = 1'b0;
                end
                default: begin
                    n_closed = r_closed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_count  <= '0;
            r_first  <= '0;
            r_povf   <= 1'b0;
            r_tovf   <= 1'b0;
            r_closed <= 1'b1;
            r_chk    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_count  <= n_count;
            r_first  <= n_first;
            r_povf   <= n_povf;
            r_tovf   <= n_tovf;
            r_closed <= n_closed;
            r_chk    <= n_chk;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opos  <= n_opos;
        r_opovf <= n_opovf;
        r_otovf <= n_otovf;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(24 - fsp_pkg::POS_W){1'b0}}, r_opos};
    assign o_m_axis_tuser  = {r_otovf, r_opovf};

    // checks
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= fsp_pkg::PATTERN_MAX_C)
        else $error("pattern length beyond capacity");

    a_first_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first != '0) |-> (r_first <= fsp_pkg::POS_W'(r_count)))
        else $error("match position beyond text count");

    a_chk_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> r_closed)
        else $error("pending compare while pattern open");

    a_tovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tovf |-> (r_count == fsp_pkg::TEXT_MAX_C))
        else $error("text overflow without saturated count");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(s_acc && (op == fsp_pkg::OP_TXT_END)))
        else $error("result without end of text");

endmodule

`default_nettype wire

// ----- src/fsp_cell.sv -----
// fsp_cell: one compare cell of the search row, holding one pattern byte,
// its active bit and one text window byte; depends on fsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsp_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire fsp_pkg::t_cell_ctrl         i_ctrl,
    input  wire  [fsp_pkg::BYTE_W-1:0]       i_pat,
    input  wire                              i_act,
    input  wire  [fsp_pkg::BYTE_W-1:0]       i_txt,
    output logic [fsp_pkg::BYTE_W-1:0]       o_pat,
    output logic                             o_act,
    output logic [fsp_pkg::BYTE_W-1:0]       o_txt,
    output logic                             o_eq
);

    logic [fsp_pkg::BYTE_W-1:0] r_pat;
    logic [fsp_pkg::BYTE_W-1:0] r_txt;
    logic                       r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctrl.pat_shift) begin
            r_act <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_ctrl.txt_shift) begin
            r_txt <= i_txt;
        end
    end

    assign o_pat = r_pat;
    assign o_act = r_act;
    assign o_txt = r_txt;
    // inactive cells lie beyond the pattern and never veto a match
    assign o_eq  = !r_act || (r_pat == r_txt);

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking stream testbench for first_substring_position_top;
// directed table plus random pattern/text searches, checked against a local
// search predictor; depends on fsp_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned DIR_ROWS = 22;

    typedef struct packed {
        logic [fsp_pkg::POS_W-1:0] pos;
        logic                      pat_long;
        logic                      txt_long;
    } t_search_result;

    typedef struct packed {
        fsp_pkg::t_op   op;
        logic [7:0]     val;
        logic [31:0]    reps;
        logic           typed;
        t_search_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    wire         o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] byte_value
    logic [1:0]  i_s_axis_tuser;   // [1:0] operation
    wire         o_m_axis_tvalid;
    logic        i_m_axis_tready;
    wire  [23:0] o_m_axis_tdata;   // [16:0] match_position, rest zero
    wire  [1:0]  o_m_axis_tuser;   // [0] pattern_too_long, [1] text_too_long

    first_substring_position_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // search predictor state
    logic [7:0]                pat_mem [fsp_pkg::PATTERN_MAX];
    int unsigned               pat_len;
    logic [7:0]                win [fsp_pkg::PATTERN_MAX];
    logic [fsp_pkg::CNT_W-1:0] txt_cnt;
    logic [fsp_pkg::POS_W-1:0] first_pos;
    bit                        pat_ovf;
    bit                        txt_ovf;
    bit                        pat_closed;

    t_search_result   pending_results [$];
    t_search_result   exp_res;
    int unsigned      items_sent;
    int unsigned      results_seen;
    int unsigned      pat_long_seen;
    int unsigned      txt_long_seen;
    int unsigned      err_cnt;
    int unsigned      idle_cycles;
    bit               quiet;
    bit               hold_req;

    function automatic void clear_text();
        for (int k = 0; k < fsp_pkg::PATTERN_MAX; k++) win[k] = 8'h00;
        txt_cnt = '0;
        first_pos = '0;
        txt_ovf = 1'b0;
    endfunction

    task automatic search_step(input fsp_pkg::t_op op, input logic [7:0] val,
                               output bit got, output t_search_result r);
        bit hit;
        got = 1'b0;
        r = '0;
        case (op)
            fsp_pkg::OP_PAT_BYTE: begin
                if (pat_closed) begin
                    pat_closed = 1'b0;
                    pat_len = 0;
                    pat_ovf = 1'b0;
                    clear_text();
                end
                if (pat_len < fsp_pkg::PATTERN_MAX) begin
                    pat_mem[pat_len] = val;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
            end
            fsp_pkg::OP_PAT_END: begin
                pat_closed = 1'b1;
                clear_text();
            end
            default: begin
                // open pattern is closed by any text transaction
                if (!pat_closed) begin
                    pat_closed = 1'b1;
                    clear_text();
                end
                if (op == fsp_pkg::OP_TXT_BYTE) begin
                    if (txt_cnt == fsp_pkg::TEXT_MAX_C) begin
                        txt_ovf = 1'b1;
                    end else begin
                        for (int k = fsp_pkg::PATTERN_MAX - 1; k > 0; k--)
                            win[k] = win[k-1];
                        win[0] = val;
                        txt_cnt++;
                        if (first_pos == '0 && pat_len > 0 && txt_cnt >= pat_len) begin
                            hit = 1'b1;
                            for (int k = 0; k < pat_len; k++)
                                if (pat_mem[k] != win[pat_len-1-k]) hit = 1'b0;
                            if (hit)
                                first_pos = fsp_pkg::POS_W'(txt_cnt)
                                          - fsp_pkg::POS_W'(pat_len) + 1'b1;
                        end
                    end
                end else begin
                    got = 1'b1;
                    r.pos = (pat_len == 0) ? fsp_pkg::POS_W'(txt_cnt) + 1'b1 : first_pos;
                    r.pat_long = pat_ovf;
                    r.txt_long = txt_ovf;
                    clear_text();
                end
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input fsp_pkg::t_op op, input logic [7:0] val,
                             input bit typed = 1'b0, input t_search_result typed_res = '0);
        int unsigned    gap;
        bit             got;
        t_search_result r;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        search_step(op, val, got, r);
        if (got) pending_results.push_back(typed ? typed_res : r);
        items_sent++;
        @(negedge i_clk);
    endtask

    // result sink with random stalls and one long hold-off
    initial begin
        int unsigned stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with none expected: pos %0d",
                       o_m_axis_tdata[fsp_pkg::POS_W-1:0]);
                err_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                results_seen++;
                if (exp_res.pat_long) pat_long_seen++;
                if (exp_res.txt_long) txt_long_seen++;
                if (o_m_axis_tdata[fsp_pkg::POS_W-1:0] !== exp_res.pos) begin
                    $error("match_position: expected %0d, got %0d",
                           exp_res.pos, o_m_axis_tdata[fsp_pkg::POS_W-1:0]);
                    err_cnt++;
                end
                if (o_m_axis_tuser[0] !== exp_res.pat_long) begin
                    $error("pattern_too_long: expected %0b, got %0b",
                           exp_res.pat_long, o_m_axis_tuser[0]);
                    err_cnt++;
                end
                if (o_m_axis_tuser[1] !== exp_res.txt_long) begin
                    $error("text_too_long: expected %0b, got %0b",
                           exp_res.txt_long, o_m_axis_tuser[1]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("first_substring_position_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_dir_row    dir_table [DIR_ROWS];
        logic [7:0]  cur_pat [$];
        logic [7:0]  txt_buf [$];
        logic [7:0]  alpha0;
        logic [7:0]  alpha1;
        logic [7:0]  c;
        bit          wide;
        bit          hold_done;
        int unsigned rnd_start;
        int unsigned plen;
        int unsigned tlen;
        int unsigned at;
        int unsigned n;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = fsp_pkg::OP_PAT_BYTE;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        hold_done       = 1'b0;
        items_sent      = 0;
        results_seen    = 0;
        pat_long_seen   = 0;
        txt_long_seen   = 0;
        err_cnt         = 0;
        idle_cycles     = 0;

        for (int k = 0; k < fsp_pkg::PATTERN_MAX; k++) pat_mem[k] = 8'h00;
        pat_len = 0;
        pat_ovf = 1'b0;
        pat_closed = 1'b1;
        clear_text();

        dir_table = '{
            // empty pattern right after reset: position is text length plus one
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b1, {17'd1, 1'b0, 1'b0}},
            '{fsp_pkg::OP_TXT_BYTE, 8'hFF, 32'd1,     1'b0, '0},
            // run the text count into saturation
            '{fsp_pkg::OP_TXT_BYTE, 8'h00, 32'd65536, 1'b0, '0},
            '{fsp_pkg::OP_TXT_END,  8'hFF, 32'd1,     1'b1, {17'd65536, 1'b0, 1'b1}},
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b1, {17'd1, 1'b0, 1'b0}},
            '{fsp_pkg::OP_PAT_BYTE, 8'h61, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_PAT_BYTE, 8'h62, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_PAT_END,  8'h00, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h78, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h61, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h62, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h61, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h62, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b0, '0},
            // text byte while the pattern is still open
            '{fsp_pkg::OP_PAT_BYTE, 8'h80, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_BYTE, 8'h80, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b0, '0},
            // end of text while the pattern is still open
            '{fsp_pkg::OP_PAT_BYTE, 8'h7F, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b0, '0},
            // end of pattern drops the text seen so far
            '{fsp_pkg::OP_TXT_BYTE, 8'h7F, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_PAT_END,  8'hFF, 32'd1,     1'b0, '0},
            '{fsp_pkg::OP_TXT_END,  8'h00, 32'd1,     1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[r])
            repeat (dir_table[r].reps)
                send_item(dir_table[r].op, dir_table[r].val,
                          dir_table[r].typed, dir_table[r].res);

        rnd_start = items_sent;
        while (items_sent - rnd_start < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 9) == 0);
            if (!hold_done && items_sent - rnd_start > 200) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                // well-formed search over a small alphabet
                alpha0 = 8'($urandom_range(0, 255));
                alpha1 = 8'($urandom_range(0, 255));
                wide = ($urandom_range(0, 4) == 0);
                if (cur_pat.size() == 0 || $urandom_range(0, 1) == 1) begin
                    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34)
                                                         : $urandom_range(1, 5);
                    cur_pat.delete();
                    for (int i = 0; i < plen; i++) begin
                        c = wide ? 8'($urandom_range(0, 255))
                                 : ($urandom_range(0, 1) ? alpha1 : alpha0);
                        cur_pat.push_back(c);
                        send_item(fsp_pkg::OP_PAT_BYTE, c);
                    end
                    if ($urandom_range(0, 7) != 0)
                        send_item(fsp_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
                end
                tlen = $urandom_range(0, 20);
                if (cur_pat.size() > 20) tlen += cur_pat.size();
                txt_buf.delete();
                for (int i = 0; i < tlen; i++)
                    txt_buf.push_back(wide ? 8'($urandom_range(0, 255))
                                           : ($urandom_range(0, 1) ? alpha1 : alpha0));
                if ($urandom_range(0, 1) == 1 && tlen >= cur_pat.size()) begin
                    at = $urandom_range(0, tlen - cur_pat.size());
                    foreach (cur_pat[i]) txt_buf[at+i] = cur_pat[i];
                end
                foreach (txt_buf[i]) send_item(fsp_pkg::OP_TXT_BYTE, txt_buf[i]);
                send_item(fsp_pkg::OP_TXT_END, 8'($urandom_range(0, 255)));
            end else begin
                // noise: any operation, any byte
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(fsp_pkg::t_op'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
            end
        end
        quiet = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("tb_top: %0d input transactions, %0d results checked, %0d errors",
                 items_sent, results_seen, err_cnt);
        $display("tb_top: results with pattern overflow %0d, with text overflow %0d",
                 pat_long_seen, txt_long_seen);
        if (err_cnt == 0)
            $display("first_substring_position_top: match");
        else
            $display("first_substring_position_top: mismatch");
        $finish;
    end

endmodule
